// ===== sv/tadc_pkg.sv =====
// Package for the thermistor ADC to temperature converter.
// Holds field widths, channel and function codes, and the command and status
// structs passed between the controller and the datapath. No dependencies.
package tadc_pkg;

   localparam int ADC_W      = 12;
   localparam int VAL_W      = 16;
   localparam int IDX_W      = 7;
   localparam int CHAN_W     = 8;
   localparam int ENT_W      = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Interpolation arithmetic widths.
   localparam int DV_W   = VAL_W + 1;
   localparam int DX_W   = ADC_W + 1;
   localparam int PROD_W = DV_W + DX_W;
   localparam int MAG_W  = PROD_W - 1;
   localparam int DMAG_W = ADC_W;
   localparam int CNT_W  = $clog2(MAG_W);
   localparam int SUM_W  = PROD_W + 1;

   localparam logic              FUNC_WRITE   = 1'b0;
   localparam logic              FUNC_CONVERT = 1'b1;
   localparam logic [CHAN_W-1:0] CHAN_A       = 8'd1;
   localparam logic [CHAN_W-1:0] CHAN_B       = 8'd2;

   // Register index as seen in paddr[2].
   localparam logic REG_ENTRIES = 1'b0;

   typedef struct packed {
      logic accept;
      logic rd_first;
      logic rd_last;
      logic chk;
      logic srch_rd;
      logic srch_cmp;
      logic nbr_rd;
      logic mul;
      logic div_start;
      logic fin;
      logic out_load;
   } tadc_cmd_type;

   typedef struct packed {
      logic is_conv;
      logic chan_ok;
      logic outside;
      logic lo_le_hi;
      logic hit;
      logic div_done;
      logic out_free;
   } tadc_status_type;

endpackage

// ===== sv/tadc_if.sv =====
// Channel interfaces of the thermistor converter: request and response.
// Depends on tadc_pkg for the field widths.
interface tadc_req_if import tadc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic [IDX_W-1:0]         entry_index;
   logic [ADC_W-1:0]         entry_adc;
   logic signed [VAL_W-1:0]  entry_value;
   logic [ADC_W-1:0]         sample;
   logic [CHAN_W-1:0]        channel;

   modport source (output valid, func, entry_index, entry_adc, entry_value, sample, channel,
                   input ready);
   modport sink   (input valid, func, entry_index, entry_adc, entry_value, sample, channel,
                   output ready);
endinterface

interface tadc_rsp_if import tadc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [VAL_W-1:0]  temperature;
   logic                     no_table;

   modport source (output valid, temperature, no_table, input ready);
   modport sink   (input valid, temperature, no_table, output ready);
endinterface

// ===== sv/tadc_divider.sv =====
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
// Used by tadc_datapath for the interpolation term. Depends on tadc_pkg.
module tadc_divider import tadc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [PROD_W-1:0] num,
   input  logic signed [DX_W-1:0]   den,
   output logic                     done,
   output logic signed [PROD_W-1:0] quo
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DMAG_W-1:0]   rem_ff, rem_in;
   logic [MAG_W-1:0]    qm_ff, qm_in;
   logic [DMAG_W-1:0]   dm_ff, dm_in;
   logic                neg_ff, neg_in;

   logic [PROD_W-1:0]   num_neg;
   logic [DX_W-1:0]     den_neg;
   logic [DMAG_W:0]     shifted;
   logic [DMAG_W:0]     diff;
   logic                ge;
   logic [PROD_W-1:0]   qx;

   always_comb begin
      num_neg = -num;
      den_neg = -den;
      shifted = {rem_ff, qm_ff[MAG_W-1]};
      diff    = shifted - {1'b0, dm_ff};
      ge      = shifted >= {1'b0, dm_ff};
      qx      = {1'b0, qm_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      qm_in   = qm_ff;
      dm_in   = dm_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         qm_in   = num[PROD_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
         dm_in   = den[DX_W-1] ? den_neg[DMAG_W-1:0] : den[DMAG_W-1:0];
         neg_in  = num[PROD_W-1] ^ den[DX_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? diff[DMAG_W-1:0] : shifted[DMAG_W-1:0];
         qm_in  = {qm_ff[MAG_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      qm_ff  <= qm_in;
      dm_ff  <= dm_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -qx : qx;

endmodule

// ===== sv/tadc_datapath.sv =====
// Datapath of the thermistor converter: calibration store, search registers,
// interpolation multiplier, divider and output register.
// Depends on tadc_pkg and tadc_divider; driven by commands from tadc_ctrl.
module tadc_datapath import tadc_pkg::*; #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tadc_cmd_type             cmd,
   output tadc_status_type          st,
   input  logic                     req_func,
   input  logic [IDX_W-1:0]         req_entry_index,
   input  logic [ADC_W-1:0]         req_entry_adc,
   input  logic signed [VAL_W-1:0]  req_entry_value,
   input  logic [ADC_W-1:0]         req_sample,
   input  logic [CHAN_W-1:0]        req_channel,
   input  logic [ENT_W-1:0]         entries_in_use,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [VAL_W-1:0]  rsp_temperature,
   output logic                     rsp_no_table
);

   localparam int IW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int XW   = (CW > IDX_W) ? CW : IDX_W;
   localparam int EW   = (CW > ENT_W) ? CW : ENT_W;
   localparam int EN_W = ADC_W + VAL_W;

   logic [EN_W-1:0]          store_ff [TABLE_DEPTH];
   logic [EN_W-1:0]          rd_data_ff;

   logic [ADC_W-1:0]         sample_ff;
   logic [CW-1:0]            lo_ff, hi_ff, mid_ff;
   logic [ADC_W-1:0]         a0_ff, amid_ff;
   logic signed [VAL_W-1:0]  v0_ff, vmid_ff;
   logic                     below_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DX_W-1:0]   den_ff;
   logic signed [VAL_W-1:0]  res_ff;
   logic                     notab_ff;
   logic                     rsp_valid_ff;
   logic signed [VAL_W-1:0]  temp_out_ff;
   logic                     notab_out_ff;

   logic [ADC_W-1:0]         rd_adc;
   logic signed [VAL_W-1:0]  rd_val;
   logic [XW-1:0]            idx_x;
   logic                     wr_en;
   logic [EW-1:0]            ent_x, n_eff;
   logic [CW-1:0]            hi_init;
   logic [CW:0]              mid_sum;
   logic [CW-1:0]            mid_calc;
   logic                     below_now;
   logic [CW-1:0]            nbr_addr;
   logic                     rd_en;
   logic [IW-1:0]            rd_addr;
   logic signed [DV_W-1:0]   dv;
   logic signed [DX_W-1:0]   dx, den_calc;
   logic signed [PROD_W-1:0] prod_calc;
   logic                     div_done;
   logic signed [PROD_W-1:0] quo;
   logic signed [PROD_W-1:0] term;
   logic signed [SUM_W-1:0]  sum;
   logic signed [VAL_W-1:0]  sat_res;

   assign rd_adc = rd_data_ff[EN_W-1:VAL_W];
   assign rd_val = rd_data_ff[VAL_W-1:0];

   // Request decode and write of one table entry.
   always_comb begin
      idx_x   = XW'(req_entry_index);
      wr_en   = cmd.accept && (req_func == FUNC_WRITE) && (idx_x < XW'(TABLE_DEPTH));
      ent_x   = EW'(entries_in_use);
      if (ent_x == '0) begin
         n_eff = EW'(1);
      end else if (ent_x > EW'(TABLE_DEPTH)) begin
         n_eff = EW'(TABLE_DEPTH);
      end else begin
         n_eff = ent_x;
      end
      hi_init = CW'(n_eff - EW'(1));
   end

   always_comb begin
      mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid_calc  = mid_sum[CW:1];
      below_now = sample_ff < amid_ff;
      nbr_addr  = below_now ? (mid_ff - 1'b1) : (mid_ff + 1'b1);

      rd_en   = 1'b1;
      rd_addr = '0;
      if (cmd.rd_first) begin
         rd_addr = '0;
      end else if (cmd.rd_last) begin
         rd_addr = hi_ff[IW-1:0];
      end else if (cmd.srch_rd) begin
         rd_addr = mid_calc[IW-1:0];
      end else if (cmd.nbr_rd) begin
         rd_addr = nbr_addr[IW-1:0];
      end else begin
         rd_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[idx_x[IW-1:0]] <= {req_entry_adc, req_entry_value};
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // Interpolation operands; the neighbour entry sits in rd_data_ff.
   always_comb begin
      if (below_ff) begin
         dv       = {rd_val[VAL_W-1], rd_val} - {vmid_ff[VAL_W-1], vmid_ff};
         dx       = $signed({1'b0, amid_ff}) - $signed({1'b0, sample_ff});
         den_calc = $signed({1'b0, amid_ff}) - $signed({1'b0, rd_adc});
      end else begin
         dv       = {vmid_ff[VAL_W-1], vmid_ff} - {rd_val[VAL_W-1], rd_val};
         dx       = $signed({1'b0, sample_ff}) - $signed({1'b0, amid_ff});
         den_calc = $signed({1'b0, rd_adc}) - $signed({1'b0, amid_ff});
      end
      prod_calc = dv * dx;
   end

   tadc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (prod_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (quo)
   );

   // Equal neighbouring codes give a zero term; the sum saturates to 16 bits.
   always_comb begin
      term = (den_ff == '0) ? '0 : quo;
      if (below_ff) begin
         sum = SUM_W'(vmid_ff) + SUM_W'(term);
      end else begin
         sum = SUM_W'(vmid_ff) - SUM_W'(term);
      end
      if ((&sum[SUM_W-1:VAL_W-1]) || !(|sum[SUM_W-1:VAL_W-1])) begin
         sat_res = sum[VAL_W-1:0];
      end else if (sum[SUM_W-1]) begin
         sat_res = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sat_res = {1'b0, {(VAL_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
         lo_ff     <= '0;
         hi_ff     <= hi_init;
         res_ff    <= '0;
         notab_ff  <= !st.chan_ok;
      end
      if (cmd.rd_last) begin
         a0_ff <= rd_adc;
         v0_ff <= rd_val;
      end
      if (cmd.chk && st.outside) begin
         res_ff <= (sample_ff <= a0_ff) ? v0_ff : rd_val;
      end
      if (cmd.srch_rd) begin
         mid_ff <= mid_calc;
      end
      if (cmd.srch_cmp) begin
         amid_ff <= rd_adc;
         vmid_ff <= rd_val;
         if (rd_adc > sample_ff) begin
            hi_ff <= mid_ff - 1'b1;
         end else if (rd_adc < sample_ff) begin
            lo_ff <= mid_ff + 1'b1;
         end
      end
      if (cmd.nbr_rd) begin
         below_ff <= below_now;
      end
      if (cmd.mul) begin
         prod_ff <= prod_calc;
         den_ff  <= den_calc;
      end
      if (cmd.fin) begin
         res_ff <= sat_res;
      end
      if (cmd.out_load) begin
         temp_out_ff  <= res_ff;
         notab_out_ff <= notab_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      st.is_conv  = req_func == FUNC_CONVERT;
      st.chan_ok  = (req_channel == CHAN_A) || (req_channel == CHAN_B);
      st.outside  = (sample_ff <= a0_ff) || (sample_ff >= rd_adc);
      st.lo_le_hi = lo_ff <= hi_ff;
      st.hit      = rd_adc == sample_ff;
      st.div_done = div_done;
      st.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = temp_out_ff;
   assign rsp_no_table    = notab_out_ff;

endmodule

// ===== sv/tadc_ctrl.sv =====
// Controller of the thermistor converter: sequences table reads, the binary
// search, the divide and the output transfer. Depends on tadc_pkg.
module tadc_ctrl import tadc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  tadc_status_type st,
   output tadc_cmd_type    cmd
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_RD0   = 12'b0000_0000_0010,
      S_RDHI  = 12'b0000_0000_0100,
      S_CHK   = 12'b0000_0000_1000,
      S_SRD   = 12'b0000_0001_0000,
      S_SCMP  = 12'b0000_0010_0000,
      S_NRD   = 12'b0000_0100_0000,
      S_MUL   = 12'b0000_1000_0000,
      S_DIV   = 12'b0001_0000_0000,
      S_DWAIT = 12'b0010_0000_0000,
      S_FIN   = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } tadc_state_type;

   tadc_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (st.is_conv) begin
                  state_in = st.chan_ok ? S_RD0 : S_DONE;
               end
            end
         end
         S_RD0: begin
            cmd.rd_first = 1'b1;
            state_in     = S_RDHI;
         end
         S_RDHI: begin
            cmd.rd_last = 1'b1;
            state_in    = S_CHK;
         end
         S_CHK: begin
            cmd.chk  = 1'b1;
            state_in = st.outside ? S_DONE : S_SRD;
         end
         S_SRD: begin
            if (st.lo_le_hi) begin
               cmd.srch_rd = 1'b1;
               state_in    = S_SCMP;
            end else begin
               state_in = S_NRD;
            end
         end
         S_SCMP: begin
            cmd.srch_cmp = 1'b1;
            state_in     = st.hit ? S_NRD : S_SRD;
         end
         S_NRD: begin
            cmd.nbr_rd = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (st.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/thermistor_adc_to_temperature_core.sv =====
// Top level of the thermistor ADC to temperature converter.
// Depends on tadc_pkg, tadc_if, tadc_ctrl and tadc_datapath.
//
// Usage:
//  - req_chan carries one item per transfer. With func at 0 the item writes
//    one calibration entry (slot, ADC code, value) and gives no result.
//    With func at 1 the item converts a sample and gives one result on
//    rsp_chan.
//  - entries_in_use is set through the APB port at address 0 and must only
//    be changed while the block is idle. Zero counts as one entry.
//  - A conversion runs a binary search over the table, of at most log2 of
//    the entry count plus one steps, and then a divide. Its length is set by
//    the single registered read port of the table, used once per search
//    step, and by the divider, which produces one quotient bit per cycle for
//    a 29-bit quotient magnitude. A sample at or beyond either end of the
//    table, or an unknown channel, skips the search and the divide.
//  - One conversion is in flight at a time; the next item is taken as soon
//    as its result sits in the output register, even if rsp_chan stalls.
//  - Reset clears the control state and sets entries_in_use to one. The
//    table itself is not cleared; only written entries may be used.
module thermistor_adc_to_temperature_core import tadc_pkg::*; #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   tadc_req_if.sink              req_chan,
   tadc_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   tadc_cmd_type    cmd;
   tadc_status_type st;
   logic [ENT_W-1:0] entries_ff;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_ENTRIES);

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENT_W'(1);
      end else if (csr_wr) begin
         entries_ff <= csr_pwdata[ENT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ENTRIES) ? CSR_DATA_W'(entries_ff) : '0;

   tadc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   tadc_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_func        (req_chan.func),
      .req_entry_index (req_chan.entry_index),
      .req_entry_adc   (req_chan.entry_adc),
      .req_entry_value (req_chan.entry_value),
      .req_sample      (req_chan.sample),
      .req_channel     (req_chan.channel),
      .entries_in_use  (entries_ff),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_temperature (rsp_chan.temperature),
      .rsp_no_table    (rsp_chan.no_table)
   );

endmodule

// ===== sv/tadc_checker.sv =====
// Port-level checker for the thermistor converter, bound to the top level.
// Depends on tadc_pkg and thermistor_adc_to_temperature_core.
module tadc_checker import tadc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_func,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata
);

   // A result that is not taken stays on offer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // A convert transfer starts work, so no new item is taken next cycle.
   a_conv_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_CONVERT) |=> !req_ready)
      else $error("request taken while a conversion is in progress");

   // A table write completes at once and leaves the block ready.
   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_WRITE) |=> req_ready)
      else $error("table write stalled the request channel");

   // A result only rises once the request channel has been held not ready.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result raised without a conversion");

   // The entry count reads back what was written.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_ENTRIES)
      |=> csr_paddr[2] != REG_ENTRIES
          || csr_prdata == CSR_DATA_W'($past(csr_pwdata[ENT_W-1:0])))
      else $error("entry count read back wrong");

endmodule

bind thermistor_adc_to_temperature_core tadc_checker u_tadc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_func    (req_chan.func),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);
